// ===== design/clas_pkg.sv =====
// Shared types, constants and keyword tables for the command line assembler store.
`timescale 1ns / 1ps
package clas_pkg;

  localparam int LINE_DEPTH_DEF   = 128;
  localparam int SCRIPT_DEPTH_DEF = 1024;

  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam int TIME_KW_LEN  = 5;
  localparam int RESET_KW_LEN = 6;

  localparam logic [2:0] OP_FEED  = 3'd0;
  localparam logic [2:0] OP_FLUSH = 3'd1;
  localparam logic [2:0] OP_BATCH = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_TAKE  = 3'd4;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_LINE  = 2'd1;
  localparam logic [1:0] EV_TIME  = 2'd2;
  localparam logic [1:0] EV_RESET = 2'd3;

  typedef enum logic [2:0] {
    K_FEED_CHAR,
    K_FEED_NL,
    K_FLUSH,
    K_BATCH,
    K_READ,
    K_TAKE,
    K_NOP
  } cmd_kind_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] data_byte;
    logic [9:0] read_address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [30:0] time_seconds;
    logic [9:0]  script_length;
    logic        script_truncated;
    logic        dirty_flag;
    logic [7:0]  read_data;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data_byte;
    logic [9:0] read_address;
  } cmd_t;

  function automatic logic [7:0] kw_time_byte(input logic [2:0] j);
    logic [7:0] b;
    case (j)
      3'd0: b = 8'h54; // T
      3'd1: b = 8'h49; // I
      3'd2: b = 8'h4D; // M
      3'd3: b = 8'h45; // E
      3'd4: b = 8'h28; // (
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] kw_reset_byte(input logic [2:0] j);
    logic [7:0] b;
    case (j)
      3'd0: b = 8'h52; // R
      3'd1: b = 8'h45; // E
      3'd2: b = 8'h53; // S
      3'd3: b = 8'h45; // E
      3'd4: b = 8'h54; // T
      3'd5: b = 8'h28; // (
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== design/clas_front.sv =====
// Front end: accepts items, classifies the opcode and holds them in a two-entry queue.
`timescale 1ns / 1ps
module clas_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  clas_pkg::in_item_t  in_item,
  output logic                in_full,
  output logic                cmd_valid,
  output clas_pkg::cmd_t      cmd,
  input  logic                cmd_pop
);

  clas_pkg::cmd_t slot0_r, slot1_r;
  logic [1:0]     cnt_r;
  clas_pkg::cmd_t new_cmd;
  logic           push, pop;

  always_comb begin
    new_cmd.data_byte    = in_item.data_byte;
    new_cmd.read_address = in_item.read_address;
    case (in_item.opcode)
      clas_pkg::OP_FEED: begin
        new_cmd.kind = (in_item.data_byte == clas_pkg::CHAR_NL) ?
                       clas_pkg::K_FEED_NL : clas_pkg::K_FEED_CHAR;
      end
      clas_pkg::OP_FLUSH: new_cmd.kind = clas_pkg::K_FLUSH;
      clas_pkg::OP_BATCH: new_cmd.kind = clas_pkg::K_BATCH;
      clas_pkg::OP_READ:  new_cmd.kind = clas_pkg::K_READ;
      clas_pkg::OP_TAKE:  new_cmd.kind = clas_pkg::K_TAKE;
      default:            new_cmd.kind = clas_pkg::K_NOP;
    endcase
  end

  assign in_full   = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = slot0_r;
  assign push      = in_push && !in_full;
  assign pop       = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (cnt_r == 2'd1) begin
        slot0_r <= new_cmd;
      end else begin
        slot0_r <= slot1_r;
        slot1_r <= new_cmd;
      end
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        slot0_r <= new_cmd;
      end else begin
        slot1_r <= new_cmd;
      end
    end else if (pop) begin
      slot0_r <= slot1_r;
    end
  end

endmodule

// ===== design/clas_back.sv =====
// Back end: line buffer, commit sequencer, time parser and script store.
`timescale 1ns / 1ps
module clas_back #(
  parameter int LINE_DEPTH   = clas_pkg::LINE_DEPTH_DEF,
  parameter int SCRIPT_DEPTH = clas_pkg::SCRIPT_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  input  clas_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  output logic                res_valid,
  output clas_pkg::out_item_t res,
  input  logic                res_ready
);

  localparam int LL_W = $clog2(LINE_DEPTH);
  localparam int SA_W = $clog2(SCRIPT_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_APPEND, S_NEWLINE, S_RDWAIT, S_DONE
  } state_t;

  typedef enum logic [1:0] {P_SPACE, P_DIGIT, P_STOP} parse_t;

  logic [7:0] line_mem   [LINE_DEPTH-1];
  logic [7:0] script_mem [SCRIPT_DEPTH];

  state_t        state_r, state_nxt;
  parse_t        pst_r, pst_nxt;
  logic [LL_W-1:0] len_r, len_nxt, idx_r, idx_nxt, pidx_r, pidx_nxt;
  logic [SA_W-1:0] cnt_r, cnt_nxt;
  logic          trunc_r, trunc_nxt, armed_r, armed_nxt, dirty_r, dirty_nxt;
  logic          pend_r, pend_nxt, tm_r, tm_nxt, rm_r, rm_nxt, neg_r, neg_nxt;
  logic          inrange_r, inrange_nxt, dbefore_r, dbefore_nxt;
  logic [31:0]   val_r, val_nxt;
  logic [1:0]    ev_r, ev_nxt;
  logic [30:0]   secs_r, secs_nxt;
  logic [7:0]    rd_r, rd_nxt;

  logic [7:0]    line_q_r, script_q_r;
  logic          line_we, script_we;
  logic [7:0]    script_wdata;
  logic [SA_W-1:0] script_raddr;
  logic          issue, is_digit;
  logic [31:0]   tval;

  assign script_raddr = SA_W'(cmd.read_address);
  assign is_digit = (line_q_r >= clas_pkg::CHAR_ZERO) && (line_q_r <= clas_pkg::CHAR_NINE);

  always_ff @(posedge clk) begin
    if (line_we) begin
      line_mem[len_r] <= cmd.data_byte;
    end
    line_q_r <= line_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (script_we) begin
      script_mem[cnt_r] <= script_wdata;
    end
    script_q_r <= script_mem[script_raddr];
  end

  always_comb begin
    state_nxt   = state_r;
    pst_nxt     = pst_r;
    len_nxt     = len_r;
    idx_nxt     = idx_r;
    pidx_nxt    = pidx_r;
    cnt_nxt     = cnt_r;
    trunc_nxt   = trunc_r;
    armed_nxt   = armed_r;
    dirty_nxt   = dirty_r;
    pend_nxt    = 1'b0;
    tm_nxt      = tm_r;
    rm_nxt      = rm_r;
    neg_nxt     = neg_r;
    val_nxt     = val_r;
    inrange_nxt = inrange_r;
    dbefore_nxt = dbefore_r;
    ev_nxt      = ev_r;
    secs_nxt    = secs_r;
    rd_nxt      = rd_r;
    cmd_pop     = 1'b0;
    line_we     = 1'b0;
    script_we   = 1'b0;
    script_wdata = line_q_r;
    issue       = 1'b0;
    tval        = neg_r ? (32'd0 - val_r) : val_r;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop     = 1'b1;
          dbefore_nxt = dirty_r;
          ev_nxt      = clas_pkg::EV_NONE;
          secs_nxt    = '0;
          rd_nxt      = '0;
          idx_nxt     = '0;
          tm_nxt      = 1'b1;
          rm_nxt      = 1'b1;
          neg_nxt     = 1'b0;
          val_nxt     = '0;
          pst_nxt     = P_SPACE;
          state_nxt   = S_DONE;
          case (cmd.kind)
            clas_pkg::K_FEED_CHAR: begin
              if (32'(len_r) < LINE_DEPTH - 1) begin
                line_we = 1'b1;
                len_nxt = len_r + 1'b1;
              end else begin
                trunc_nxt = 1'b1;
                state_nxt = S_SCAN;
              end
            end
            clas_pkg::K_FEED_NL: state_nxt = S_SCAN;
            clas_pkg::K_FLUSH: begin
              if (len_r != '0) state_nxt = S_SCAN;
            end
            clas_pkg::K_BATCH: armed_nxt = 1'b1;
            clas_pkg::K_READ: begin
              inrange_nxt = (32'(cmd.read_address) < SCRIPT_DEPTH);
              state_nxt   = S_RDWAIT;
            end
            clas_pkg::K_TAKE: dirty_nxt = 1'b0;
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_SCAN: begin
        // one read in flight; the keyword flags trail the issued reads, so an extra read is harmless
        issue = (idx_r < len_r) && (rm_r || (tm_r && pst_r != P_STOP));
        if (issue) begin
          idx_nxt  = idx_r + 1'b1;
          pidx_nxt = idx_r;
          pend_nxt = 1'b1;
        end
        if (pend_r) begin
          if (32'(pidx_r) < clas_pkg::TIME_KW_LEN &&
              line_q_r != clas_pkg::kw_time_byte(3'(pidx_r))) begin
            tm_nxt = 1'b0;
          end
          if (32'(pidx_r) < clas_pkg::RESET_KW_LEN &&
              line_q_r != clas_pkg::kw_reset_byte(3'(pidx_r))) begin
            rm_nxt = 1'b0;
          end
          if (32'(pidx_r) >= clas_pkg::TIME_KW_LEN && tm_r) begin
            case (pst_r)
              P_SPACE: begin
                if (line_q_r == clas_pkg::CHAR_SPACE) begin
                  pst_nxt = P_SPACE;
                end else if (line_q_r == clas_pkg::CHAR_MINUS) begin
                  neg_nxt = 1'b1;
                  pst_nxt = P_DIGIT;
                end else if (is_digit) begin
                  val_nxt = {28'd0, line_q_r[3:0]};
                  pst_nxt = P_DIGIT;
                end else begin
                  pst_nxt = P_STOP;
                end
              end
              P_DIGIT: begin
                if (is_digit) begin
                  val_nxt = (val_r << 3) + (val_r << 1) + {28'd0, line_q_r[3:0]};
                end else begin
                  pst_nxt = P_STOP;
                end
              end
              default: pst_nxt = P_STOP;
            endcase
          end
        end
        if (!pend_r && !issue) state_nxt = S_DECIDE;
      end

      S_DECIDE: begin
        idx_nxt = '0;
        if (tm_r && 32'(len_r) >= clas_pkg::TIME_KW_LEN) begin
          if (tval != 32'd0 && !tval[31]) begin
            ev_nxt   = clas_pkg::EV_TIME;
            secs_nxt = tval[30:0];
          end
          len_nxt   = '0;
          state_nxt = S_DONE;
        end else if (rm_r && 32'(len_r) >= clas_pkg::RESET_KW_LEN) begin
          armed_nxt = 1'b1;
          ev_nxt    = clas_pkg::EV_RESET;
          len_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          if (armed_r) begin
            armed_nxt = 1'b0;
            cnt_nxt   = '0;
            trunc_nxt = 1'b0;
          end
          dirty_nxt = 1'b1;
          ev_nxt    = clas_pkg::EV_LINE;
          state_nxt = S_APPEND;
        end
      end

      S_APPEND: begin
        issue = (idx_r < len_r);
        if (issue) begin
          idx_nxt  = idx_r + 1'b1;
          pend_nxt = 1'b1;
        end
        if (pend_r) begin
          if (32'(cnt_r) < SCRIPT_DEPTH - 1) begin
            script_we = 1'b1;
            cnt_nxt   = cnt_r + 1'b1;
          end else begin
            trunc_nxt = 1'b1;
          end
        end
        if (!pend_r && !issue) state_nxt = S_NEWLINE;
      end

      S_NEWLINE: begin
        // newline that finds the store full is dropped without marking
        script_wdata = clas_pkg::CHAR_NL;
        if (32'(cnt_r) < SCRIPT_DEPTH - 1) begin
          script_we = 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
        end
        len_nxt   = '0;
        state_nxt = S_DONE;
      end

      S_RDWAIT: begin
        rd_nxt    = inrange_r ? script_q_r : 8'd0;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (res_ready) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= '0;
      cnt_r   <= '0;
      trunc_r <= 1'b0;
      armed_r <= 1'b0;
      dirty_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      trunc_r <= trunc_nxt;
      armed_r <= armed_nxt;
      dirty_r <= dirty_nxt;
      pend_r  <= pend_nxt;
    end
    pst_r     <= pst_nxt;
    idx_r     <= idx_nxt;
    pidx_r    <= pidx_nxt;
    tm_r      <= tm_nxt;
    rm_r      <= rm_nxt;
    neg_r     <= neg_nxt;
    val_r     <= val_nxt;
    inrange_r <= inrange_nxt;
    dbefore_r <= dbefore_nxt;
    ev_r      <= ev_nxt;
    secs_r    <= secs_nxt;
    rd_r      <= rd_nxt;
  end

  assign res_valid = (state_r == S_DONE);
  always_comb begin
    res.event_kind       = ev_r;
    res.time_seconds     = secs_r;
    res.script_length    = 10'(cnt_r);
    res.script_truncated = trunc_r;
    res.dirty_flag       = dbefore_r;
    res.read_data        = rd_r;
  end

endmodule

// ===== design/command_line_assembler_store.sv =====
// Top level of the command line assembler store: front queue, back end and result register.
`timescale 1ns / 1ps
// Each item gives exactly one result. Byte feeds that do not commit, batch, take and unused
// opcodes go straight to the result, and a script read passes through the read wait state.
// A commit scans the buffered line once through the line buffer's read port (cut short once
// neither keyword can match or the time value has ended), and a stored line then streams
// through it again into the script store, one byte a cycle, plus the newline. A two-entry
// input queue and a result register let both sides stall freely.
module command_line_assembler_store #(
  parameter int LINE_DEPTH   = clas_pkg::LINE_DEPTH_DEF,
  parameter int SCRIPT_DEPTH = clas_pkg::SCRIPT_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  clas_pkg::in_item_t  in_item,
  output logic                in_full,
  output logic                out_empty,
  input  logic                out_pop,
  output clas_pkg::out_item_t out_item
);

  logic                cmd_valid, cmd_pop, res_valid, res_ready;
  clas_pkg::cmd_t      cmd;
  clas_pkg::out_item_t res;
  logic                out_valid_r;
  clas_pkg::out_item_t out_item_r;

  clas_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  clas_back #(
    .LINE_DEPTH   (LINE_DEPTH),
    .SCRIPT_DEPTH (SCRIPT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  assign res_ready = !out_valid_r || out_pop;
  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_item_r <= res;
    end
  end

endmodule

// ===== verif/command_line_assembler_store_test.sv =====
// Testbench for the command line assembler store: line builder, script store and result checks.
`timescale 1ns / 1ps
module command_line_assembler_store_test;

  localparam int LDEPTH = clas_pkg::LINE_DEPTH_DEF;
  localparam int SDEPTH = clas_pkg::SCRIPT_DEPTH_DEF;
  localparam int WATCHDOG_LIMIT = 20000;

  class line_scoreboard;
    logic [7:0] line_buf[LDEPTH];
    int unsigned line_cnt;
    logic [7:0] script_buf[SDEPTH];
    int unsigned script_cnt;
    bit trunc, armed, dirty;
    clas_pkg::out_item_t pending[$];
    int unsigned mismatches;

    function void clear_state();
      line_cnt = 0; script_cnt = 0; trunc = 0; armed = 0; dirty = 0;
      mismatches = 0;
      pending.delete();
      foreach (script_buf[i]) script_buf[i] = 8'h00;
    endfunction

    function bit starts_with_time();
      if (line_cnt < clas_pkg::TIME_KW_LEN) return 0;
      return line_buf[0] == "T" && line_buf[1] == "I" && line_buf[2] == "M" &&
             line_buf[3] == "E" && line_buf[4] == "(";
    endfunction

    function bit starts_with_reset();
      if (line_cnt < clas_pkg::RESET_KW_LEN) return 0;
      return line_buf[0] == "R" && line_buf[1] == "E" && line_buf[2] == "S" &&
             line_buf[3] == "E" && line_buf[4] == "T" && line_buf[5] == "(";
    endfunction

    function void append_byte(logic [7:0] b, bit mark_full);
      if (script_cnt < SDEPTH - 1) begin
        script_buf[script_cnt] = b;
        script_cnt++;
      end else if (mark_full) begin
        trunc = 1;
      end
    endfunction

    // Returns event kind; secs is the parsed time when positive.
    function logic [1:0] commit_line(output logic [30:0] secs);
      int unsigned k;
      logic [31:0] val;
      bit neg;
      secs = '0;
      if (starts_with_time()) begin
        val = 0; neg = 0; k = clas_pkg::TIME_KW_LEN;
        while (k < line_cnt && line_buf[k] == clas_pkg::CHAR_SPACE) k++;
        if (k < line_cnt && line_buf[k] == clas_pkg::CHAR_MINUS) begin
          neg = 1; k++;
        end
        while (k < line_cnt && line_buf[k] >= clas_pkg::CHAR_ZERO &&
               line_buf[k] <= clas_pkg::CHAR_NINE) begin
          val = val * 32'd10 + 32'(line_buf[k] - clas_pkg::CHAR_ZERO);
          k++;
        end
        if (neg) val = 32'd0 - val;
        if (val != 0 && !val[31]) begin
          secs = val[30:0];
          return clas_pkg::EV_TIME;
        end
        return clas_pkg::EV_NONE;
      end
      if (starts_with_reset()) begin
        armed = 1;
        return clas_pkg::EV_RESET;
      end
      if (armed) begin
        armed = 0; script_cnt = 0; trunc = 0;
      end
      dirty = 1;
      for (int i = 0; i < line_cnt; i++) append_byte(line_buf[i], 1);
      append_byte(clas_pkg::CHAR_NL, 0);
      return clas_pkg::EV_LINE;
    endfunction

    function void note_input(clas_pkg::in_item_t it);
      clas_pkg::out_item_t r;
      logic [30:0] secs;
      r = '0;
      r.dirty_flag = dirty;
      secs = '0;
      case (it.opcode)
        clas_pkg::OP_FEED: begin
          if (it.data_byte == clas_pkg::CHAR_NL) begin
            r.event_kind = commit_line(secs);
            line_cnt = 0;
          end else if (line_cnt < LDEPTH - 1) begin
            line_buf[line_cnt] = it.data_byte;
            line_cnt++;
          end else begin
            trunc = 1;
            r.event_kind = commit_line(secs);
            line_cnt = 0;
          end
        end
        clas_pkg::OP_FLUSH: begin
          if (line_cnt != 0) begin
            r.event_kind = commit_line(secs);
            line_cnt = 0;
          end
        end
        clas_pkg::OP_BATCH: armed = 1;
        clas_pkg::OP_READ: r.read_data = script_buf[it.read_address];
        clas_pkg::OP_TAKE: dirty = 0;
        default: ;
      endcase
      r.time_seconds = secs;
      r.script_length = script_cnt[9:0];
      r.script_truncated = trunc;
      pending.push_back(r);
    endfunction

    function void check_result(clas_pkg::out_item_t got);
      clas_pkg::out_item_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %p", got);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result mismatch: expected %p, got %p", exp, got);
      end
    endfunction
  endclass

  logic clk, rst_n, in_push, out_pop, in_full, out_empty;
  clas_pkg::in_item_t in_item;
  clas_pkg::out_item_t out_item;
  line_scoreboard sb;
  int unsigned idle_cycles;
  int unsigned stall_mode;

  command_line_assembler_store u_top (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_item(in_item), .in_full(in_full),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item)
  );

  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  // Receiver: stall pattern changes at random moments; mode 0 never stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (!out_empty && out_pop) sb.check_result(out_item);
      if ($urandom_range(0, 299) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_pop <= 1'b1;
        1: out_pop <= ($urandom_range(0, 3) != 0);
        2: out_pop <= ($urandom_range(0, 1) != 0);
        default: out_pop <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  int unsigned burst_left;
  int unsigned sent;

  // Sends one item, waiting for acceptance; inserts gaps between bursts.
  task automatic send_item(clas_pkg::in_item_t it);
    int unsigned gap;
    bit taken;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? $urandom_range(1, 12) : 0;
      if (gap != 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_push <= 1'b1;
    in_item <= it;
    // full only changes at rising edges, so its value at the falling edge decides acceptance
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_full;
      @(posedge clk);
    end
    sb.note_input(it);
    burst_left--;
    sent++;
  endtask

  task automatic send_op(logic [2:0] op, logic [7:0] b, logic [9:0] a);
    clas_pkg::in_item_t it;
    it.opcode = op; it.data_byte = b; it.read_address = a;
    send_item(it);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_op(clas_pkg::OP_FEED, s[i], 10'($urandom));
  endtask

  // Reads a script position that has been written, or sends a take while the script is empty.
  task automatic send_read();
    logic [9:0] a;
    if (sb.script_cnt == 0) a = '0;
    else a = 10'($urandom_range(0, sb.script_cnt - 1));
    if (sb.script_cnt == 0) send_op(clas_pkg::OP_TAKE, 8'($urandom), 10'($urandom));
    else send_op(clas_pkg::OP_READ, 8'($urandom), a);
  endtask

  function automatic string rand_digits(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(48, 57)))};
    return s;
  endfunction

  function automatic string rand_text(int n);
    string s;
    byte unsigned c;
    s = "";
    for (int i = 0; i < n; i++) begin
      c = 8'($urandom_range(0, 255));
      if (c == clas_pkg::CHAR_NL) c = 8'hFF;
      s = {s, string'(c)};
    end
    return s;
  endfunction

  task automatic random_line();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      send_text({"TIME(", ($urandom_range(0, 1) ? "  " : ""),
                 ($urandom_range(0, 2) == 0 ? "-" : ""),
                 rand_digits($urandom_range(0, 12)), ($urandom_range(0, 1) ? ")" : "")});
    end else if (pick < 40) begin
      send_text({"RESET(", rand_text($urandom_range(0, 3))});
    end else if (pick < 47) begin
      send_text({"TIM", rand_text($urandom_range(0, 1))});
    end else if (pick < 52) begin
      send_text(rand_text($urandom_range(120, 130)));
    end else begin
      send_text(rand_text($urandom_range(0, 20)));
    end
    if ($urandom_range(0, 3) == 0)
      send_op(clas_pkg::OP_FLUSH, 8'($urandom), 10'($urandom));
    else
      send_op(clas_pkg::OP_FEED, clas_pkg::CHAR_NL, 10'($urandom));
  endtask

  initial begin
    sb = new();
    sb.clear_state();
    rst_n = 1'b0; in_push = 1'b0; in_item = '0; out_pop = 1'b0;
    stall_mode = 0; idle_cycles = 0; burst_left = 0; sent = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part.
    send_op(clas_pkg::OP_FLUSH, 8'h00, 10'h000);
    send_op(clas_pkg::OP_TAKE, 8'hFF, 10'h3FF);
    send_op(clas_pkg::OP_FEED, clas_pkg::CHAR_NL, 10'h3FF);
    send_op(clas_pkg::OP_READ, 8'h00, 10'h000);
    send_op(3'd5, 8'hFF, 10'h3FF);
    send_op(3'd7, 8'h00, 10'h000);
    send_text("TIME(-5\n");
    send_text("TIME( 2147483647)\n");
    send_text("TIME(4294967295\n");
    send_text("RESET(\n");
    send_text("ab\xff\x80");
    send_op(clas_pkg::OP_FLUSH, 8'h00, 10'h000);
    send_op(clas_pkg::OP_TAKE, 8'h00, 10'h000);
    send_op(clas_pkg::OP_BATCH, 8'h00, 10'h000);
    send_text("TIM\n");

    while (sent < 900) begin
      if ($urandom_range(0, 9) < 7) begin
        random_line();
      end else begin
        case ($urandom_range(0, 5))
          0: send_op(clas_pkg::OP_BATCH, 8'($urandom), 10'($urandom));
          1: send_op(clas_pkg::OP_TAKE, 8'($urandom), 10'($urandom));
          2: send_op(3'($urandom_range(5, 7)), 8'($urandom), 10'($urandom));
          3: send_op(clas_pkg::OP_FEED, 8'($urandom), 10'($urandom));
          default: send_read();
        endcase
      end
    end
    in_push <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
